// ----- hw/rtl/lls_pkg.sv -----
// ----------------------------------------------------------------------------
// lls_pkg: link latency statistics shared definitions
// Transfer types, sequencer codes, divider request and widths used by the
// statistics sequencer and its divider.
// ----------------------------------------------------------------------------
package lls_pkg;

  // Widths
  localparam int unsigned AccW     = 24;   // averages, 8 fraction bits
  localparam int unsigned SmpW     = 16;   // latency samples
  localparam int unsigned CntW     = 32;   // saturating counters
  localparam int unsigned PctW     = 15;   // loss percentage
  localparam int unsigned SumW     = 28;   // 9 * acc + sample * 256
  localparam int unsigned DendW    = 48;   // divider dividend
  localparam int unsigned DsorW    = 33;   // divider divisor
  localparam int unsigned StepW    = 6;    // divider step counter

  // Divider step count for the loss percentage
  localparam logic [StepW-1:0] PctSteps    = 6'd47;

  localparam logic [CntW-1:0]  CntMax      = {CntW{1'b1}};

  // floor(x / 10) = (x * RecipTen) >> RecipShift, exact for any x below 2**30
  localparam logic [SumW-1:0]  RecipTen    = 28'hCCCCCCD;
  localparam int unsigned      RecipShift  = 31;

  // Input transfer
  typedef struct packed {
    logic            received;
    logic [SmpW-1:0] latency_sample;
    logic [SmpW-1:0] round_trip;
  } lls_in_t;

  // Result transfer
  typedef struct packed {
    logic [AccW-1:0] mean_latency;
    logic [AccW-1:0] mean_round_trip;
    logic [AccW-1:0] mean_jitter;
    logic [SmpW-1:0] least_latency;
    logic [SmpW-1:0] greatest_latency;
    logic [CntW-1:0] arrived_total;
    logic [CntW-1:0] lost_total;
    logic [PctW-1:0] loss_percent;
  } lls_out_t;

  // Request to the divider
  typedef struct packed {
    logic             start;
    logic [DendW-1:0] dividend;
    logic [DsorW-1:0] divisor;
    logic [StepW-1:0] steps;
  } lls_div_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } lls_state_e;

  typedef enum logic [1:0] {
    OP_LAT,
    OP_RTT,
    OP_JIT,
    OP_PCT
  } lls_op_e;

  // First pending operation; the loss percentage always comes last
  function automatic lls_op_e first_op(input logic need_lat, input logic need_rtt,
                                       input logic need_jit);
    lls_op_e op;
    if (need_lat) begin
      op = OP_LAT;
    end else if (need_rtt) begin
      op = OP_RTT;
    end else if (need_jit) begin
      op = OP_JIT;
    end else begin
      op = OP_PCT;
    end
    return op;
  endfunction

endpackage

// ----- hw/rtl/lls_divider.sv -----
// ----------------------------------------------------------------------------
// lls_divider: radix-2 restoring divider
// Consumes one dividend bit per cycle, MSB first, for a requested number of
// steps; the dividend arrives left aligned. done_o pulses when finished.
// ----------------------------------------------------------------------------
module lls_divider
  import lls_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lls_div_req_t     req_i,
  output logic             done_o,
  output logic [DendW-1:0] quotient_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DendW-1:0] dend_q, dend_d;
  logic [DsorW-1:0] dsor_q, dsor_d;
  logic [DsorW-1:0] rem_q, rem_d;
  logic [DendW-1:0] quot_q, quot_d;
  logic [DsorW:0]   trial;
  logic [DsorW:0]   diff;
  logic             ge;

  // One shift-subtract step
  assign trial = {rem_q, dend_q[DendW-1]};
  assign ge    = (trial >= {1'b0, dsor_q});
  assign diff  = trial - {1'b0, dsor_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dend_d = dend_q;
    dsor_d = dsor_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      dend_d = req_i.dividend;
      dsor_d = req_i.divisor;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DsorW-1:0] : trial[DsorW-1:0];
      quot_d = {quot_q[DendW-2:0], ge};
      dend_d = {dend_q[DendW-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    dend_q <= dend_d;
    dsor_q <= dsor_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

// ----- hw/rtl/link_latency_statistics.sv -----
// Per item, each pending average update takes a START and a WAIT state (sum,
// then reciprocal multiply), and the loss percentage runs last on the divider.
// A new item is taken only in idle, after the last result is loaded out.
// A finished result waits in the output register while the next item starts.
// Reset (rst_ni low, asynchronous) clears all statistics and counters.
// ----------------------------------------------------------------------------
// link_latency_statistics: link latency and loss statistics
// Per packet event, updates smoothed latency, round trip and jitter, min/max
// latency, saturating counters and the loss percentage under a small sequencer.
// ----------------------------------------------------------------------------
module link_latency_statistics
  import lls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lls_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lls_out_t out_item_o
);

  lls_state_e   state_q, state_d;
  lls_op_e      op_q;
  lls_div_req_t div_req;
  logic         div_done;
  logic [DendW-1:0] div_quot;

  logic [AccW-1:0] avg_lat_q, avg_rtt_q, jit_q;
  logic [SmpW-1:0] min_q, max_q, prev_q;
  logic            have_q;
  logic [CntW-1:0] rcv_q, lost_q;
  logic [PctW-1:0] pct_q;
  logic            need_rtt_q, need_jit_q;
  logic [SmpW-1:0] lat_smp_q, rtt_smp_q, diff_q;
  logic [SumW-1:0] sum_q;
  logic            out_valid_q;
  lls_out_t        out_q;

  logic            accept;
  logic            emit_load;
  logic            op_done;
  logic            rx;
  logic [SmpW-1:0] lat, rtt, lat_diff;
  logic            n_lat, n_rtt, n_jit;
  logic [AccW-1:0] sel_acc;
  logic [SmpW-1:0] sel_smp;
  logic [SumW-1:0] smooth_sum;
  logic [2*SumW-1:0] smooth_prod;
  logic [AccW-1:0] smooth_quot;
  logic [46:0]     lost_scaled;
  logic [DsorW-1:0] total;

  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign op_done   = (state_q == ST_WAIT) && ((op_q != OP_PCT) || div_done);
  assign rx        = in_item_i.received;
  assign lat       = in_item_i.latency_sample;
  assign rtt       = in_item_i.round_trip;
  assign lat_diff  = (lat >= prev_q) ? (lat - prev_q) : (prev_q - lat);

  // Pending averages for this item
  assign n_lat = rx && have_q;
  assign n_rtt = rx && (rtt != '0) && (avg_rtt_q != '0);
  assign n_jit = rx && have_q;

  // Smoothing sum 9 * acc + sample * 256, and lost * 25600 for the divider
  always_comb begin
    case (op_q)
      OP_LAT: begin
        sel_acc = avg_lat_q;
        sel_smp = lat_smp_q;
      end
      OP_RTT: begin
        sel_acc = avg_rtt_q;
        sel_smp = rtt_smp_q;
      end
      default: begin
        sel_acc = jit_q;
        sel_smp = diff_q;
      end
    endcase
  end

  assign smooth_sum  = ({4'b0, sel_acc} << 3) + {4'b0, sel_acc} + {4'b0, sel_smp, 8'b0};
  assign lost_scaled = ({15'b0, lost_q} << 14) + ({15'b0, lost_q} << 13)
                     + ({15'b0, lost_q} << 10);
  assign total       = {1'b0, lost_q} + {1'b0, rcv_q};

  // Divide the registered sum by 10 with a reciprocal multiply
  assign smooth_prod = {{SumW{1'b0}}, sum_q} * {{SumW{1'b0}}, RecipTen};
  assign smooth_quot = smooth_prod[RecipShift+AccW-1:RecipShift];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_START;
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (op_done) state_d = (op_q == OP_PCT) ? ST_EMIT : ST_START;
      end
      ST_EMIT:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o       = (state_q != ST_IDLE);
    div_req.start    = (state_q == ST_START) && (op_q == OP_PCT);
    div_req.dividend = {lost_scaled, 1'b0};
    div_req.divisor  = total;
    div_req.steps    = PctSteps;
  end

  lls_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Statistics state and sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_PCT;
      avg_lat_q   <= '0;
      avg_rtt_q   <= '0;
      jit_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      prev_q      <= '0;
      have_q      <= 1'b0;
      rcv_q       <= '0;
      lost_q      <= '0;
      pct_q       <= '0;
      need_rtt_q  <= 1'b0;
      need_jit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        need_rtt_q <= n_rtt;
        need_jit_q <= n_jit;
        op_q       <= first_op(n_lat, n_rtt, n_jit);
        if (rx) begin
          if (!have_q) avg_lat_q <= {lat, 8'b0};
          if ((rtt != '0) && (avg_rtt_q == '0)) avg_rtt_q <= {rtt, 8'b0};
          if ((lat < min_q) || (min_q == '0)) min_q <= lat;
          if (lat > max_q) max_q <= lat;
          prev_q <= lat;
          have_q <= 1'b1;
          rcv_q  <= (rcv_q == CntMax) ? rcv_q : rcv_q + 1'b1;
        end else begin
          lost_q <= (lost_q == CntMax) ? lost_q : lost_q + 1'b1;
        end
      end
      // Write back a finished operation and pick the next one
      if (op_done) begin
        case (op_q)
          OP_LAT: begin
            avg_lat_q  <= smooth_quot;
            op_q       <= first_op(1'b0, need_rtt_q, need_jit_q);
          end
          OP_RTT: begin
            avg_rtt_q  <= smooth_quot;
            need_rtt_q <= 1'b0;
            op_q       <= first_op(1'b0, 1'b0, need_jit_q);
          end
          OP_JIT: begin
            jit_q      <= smooth_quot;
            need_jit_q <= 1'b0;
            op_q       <= OP_PCT;
          end
          default: begin
            pct_q <= div_quot[PctW-1:0];
          end
        endcase
      end
      // Output register
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item samples kept for the averages
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lat_smp_q <= lat;
      rtt_smp_q <= rtt;
      diff_q    <= lat_diff;
    end
  end

  // Smoothing sum for the pending average
  always_ff @(posedge clk_i) begin
    if (state_q == ST_START) begin
      sum_q <= smooth_sum;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_q.mean_latency     <= avg_lat_q;
      out_q.mean_round_trip  <= avg_rtt_q;
      out_q.mean_jitter      <= jit_q;
      out_q.least_latency    <= min_q;
      out_q.greatest_latency <= max_q;
      out_q.arrived_total    <= rcv_q;
      out_q.lost_total       <= lost_q;
      out_q.loss_percent     <= pct_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
